@@ hdl/sfr_pkg.sv @@
// Package with types, codes and constants shared by the serial frame receiver.
`timescale 1ns / 1ps
package sfr_pkg;

	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned REG_IDX_W = 3;

	localparam logic [BYTE_W-1:0] CRC_INIT = 8'hFF;
	localparam logic [BYTE_W-1:0] CRC_POLY = 8'h8C;
	localparam logic [BYTE_W-1:0] LEN_MIN  = 8'd6;
	localparam logic [BYTE_W-1:0] LEN_OVERHEAD = 8'd2;

	localparam logic [BYTE_W-1:0] HEAD_RST  = 8'd170;
	localparam logic [BYTE_W-1:0] TAIL_RST  = 8'd85;
	localparam logic [BYTE_W-1:0] ACK_RST   = 8'd1;
	localparam logic [BYTE_W-1:0] USER_RST  = 8'd2;
	localparam logic [BYTE_W-1:0] LIMIT_RST = 8'd64;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_HEAD  = 3'd0,
		REG_TAIL  = 3'd1,
		REG_ACK   = 3'd2,
		REG_USER  = 3'd3,
		REG_LIMIT = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_HEAD  = 3'd0,
		ST_TYPE  = 3'd1,
		ST_ADDR  = 3'd2,
		ST_LEN   = 3'd3,
		ST_UTYPE = 3'd4,
		ST_DATA  = 3'd5,
		ST_CRC   = 3'd6,
		ST_TAIL  = 3'd7
	} parse_state_t;

	typedef enum logic [2:0] {
		EV_PAYLOAD  = 3'd0,
		EV_USER_OK  = 3'd1,
		EV_ACK_OK   = 3'd2,
		EV_LEN_ERR  = 3'd3,
		EV_CRC_ERR  = 3'd4,
		EV_TAIL_ERR = 3'd5
	} ev_code_t;

	typedef struct packed {
		logic [BYTE_W-1:0] rx_byte;
	} rx_item_t;

	typedef struct packed {
		ev_code_t          event_res;
		logic [BYTE_W-1:0] byte_value;
		logic [BYTE_W-1:0] byte_index;
		logic [ADDR_W-1:0] frame_address;
		logic [BYTE_W-1:0] frame_type;
		logic [BYTE_W-1:0] frame_length;
	} ev_item_t;

	typedef struct packed {
		logic [REG_IDX_W-1:0] reg_index;
		logic [BYTE_W-1:0]    reg_data;
	} cfg_item_t;

	typedef struct packed {
		logic [BYTE_W-1:0] head_byte;
		logic [BYTE_W-1:0] tail_byte;
		logic [BYTE_W-1:0] ack_type_byte;
		logic [BYTE_W-1:0] user_type_byte;
		logic [BYTE_W-1:0] length_limit;
	} cfg_regs_t;

endpackage

@@ hdl/sfr_rx_if.sv @@
// Channel interface carrying received bytes.
`timescale 1ns / 1ps
interface sfr_rx_if;
	import sfr_pkg::*;
	logic     valid;
	logic     ready;
	rx_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ hdl/sfr_ev_if.sv @@
// Channel interface carrying frame events.
`timescale 1ns / 1ps
interface sfr_ev_if;
	import sfr_pkg::*;
	logic     valid;
	logic     ready;
	ev_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ hdl/sfr_cfg_if.sv @@
// Channel interface carrying configuration register writes.
`timescale 1ns / 1ps
interface sfr_cfg_if;
	import sfr_pkg::*;
	logic      valid;
	logic      ready;
	cfg_item_t payload;
	modport source(output valid, output payload, input ready);
	modport sink(input valid, input payload, output ready);
endinterface

@@ hdl/sfr_cfg_regs.sv @@
// Configuration register file of the frame receiver.
`timescale 1ns / 1ps
module sfr_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               wr_en,
	input  logic [sfr_pkg::REG_IDX_W-1:0]      wr_index,
	input  logic [sfr_pkg::BYTE_W-1:0]         wr_data,
	output sfr_pkg::cfg_regs_t                 regs
);
	import sfr_pkg::*;

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.head_byte      <= HEAD_RST;
			regs_q.tail_byte      <= TAIL_RST;
			regs_q.ack_type_byte  <= ACK_RST;
			regs_q.user_type_byte <= USER_RST;
			regs_q.length_limit   <= LIMIT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HEAD:  regs_q.head_byte      <= wr_data;
				REG_TAIL:  regs_q.tail_byte      <= wr_data;
				REG_ACK:   regs_q.ack_type_byte  <= wr_data;
				REG_USER:  regs_q.user_type_byte <= wr_data;
				REG_LIMIT: regs_q.length_limit   <= wr_data;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

@@ hdl/sfr_crc8.sv @@
// Bytewise CRC-8 update with the reflected polynomial.
`timescale 1ns / 1ps
module sfr_crc8 (
	input  logic [sfr_pkg::BYTE_W-1:0] crc_in,
	input  logic [sfr_pkg::BYTE_W-1:0] data_in,
	output logic [sfr_pkg::BYTE_W-1:0] crc_out
);
	import sfr_pkg::*;

	always_comb begin
		logic [BYTE_W-1:0] c;
		c = crc_in ^ data_in;
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		crc_out = c;
	end

endmodule

@@ hdl/sfr_parser.sv @@
// Frame parsing state machine with its result register.
`timescale 1ns / 1ps
module sfr_parser (
	input  logic                       clk,
	input  logic                       arst_n,
	input  sfr_pkg::cfg_regs_t         regs,
	input  logic                       rx_valid,
	output logic                       rx_ready,
	input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
	output logic                       ev_valid,
	input  logic                       ev_ready,
	output sfr_pkg::ev_item_t          ev_item
);
	import sfr_pkg::*;

	parse_state_t      state_q, state_d;
	logic              is_ack_q, is_ack_d;
	logic              addr_phase_q, addr_phase_d;
	logic [BYTE_W-1:0] addr_hi_q, addr_hi_d;
	logic [BYTE_W-1:0] addr_lo_q, addr_lo_d;
	logic [BYTE_W-1:0] len_q, len_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic [BYTE_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0] crc_q, crc_d;
	logic [BYTE_W-1:0] ack_status_q, ack_status_d;

	logic [BYTE_W-1:0] crc_in, crc_next, count_inc;
	logic              len_ok, data_done, accept;
	logic              res_valid;
	ev_item_t          res_item;
	logic              ev_valid_q;
	ev_item_t          ev_item_q;

	assign crc_in    = (state_q == ST_LEN) ? CRC_INIT : crc_q;
	assign count_inc = count_q + 8'd1;
	assign len_ok    = (rx_byte < regs.length_limit) && (rx_byte >= LEN_MIN);
	assign data_done = ({1'b0, count_inc} + {1'b0, LEN_OVERHEAD}) >= {1'b0, len_q};

	sfr_crc8 u_crc (
		.crc_in  (crc_in),
		.data_in (rx_byte),
		.crc_out (crc_next)
	);

	always_comb begin
		state_d      = state_q;
		is_ack_d     = is_ack_q;
		addr_phase_d = addr_phase_q;
		addr_hi_d    = addr_hi_q;
		addr_lo_d    = addr_lo_q;
		len_d        = len_q;
		type_d       = type_q;
		count_d      = count_q;
		crc_d        = crc_q;
		ack_status_d = ack_status_q;
		unique case (state_q)
			ST_HEAD: begin
				if (rx_byte == regs.head_byte) state_d = ST_TYPE;
			end
			ST_TYPE: begin
				if (rx_byte == regs.ack_type_byte) begin
					is_ack_d = 1'b1;
					state_d  = ST_DATA;
				end else if (rx_byte == regs.user_type_byte) begin
					is_ack_d     = 1'b0;
					addr_phase_d = 1'b0;
					state_d      = ST_ADDR;
				end else begin
					is_ack_d = 1'b0;
					state_d  = ST_HEAD;
				end
			end
			ST_ADDR: begin
				if (!addr_phase_q) begin
					addr_hi_d    = rx_byte;
					addr_phase_d = 1'b1;
				end else begin
					addr_lo_d    = rx_byte;
					addr_phase_d = 1'b0;
					state_d      = ST_LEN;
				end
			end
			ST_LEN: begin
				len_d = rx_byte;
				if (len_ok) begin
					crc_d   = crc_next;
					state_d = ST_UTYPE;
				end else begin
					type_d  = '0;
					state_d = ST_HEAD;
				end
			end
			ST_UTYPE: begin
				type_d  = rx_byte;
				crc_d   = crc_next;
				count_d = '0;
				state_d = ST_DATA;
			end
			ST_DATA: begin
				if (is_ack_q) begin
					ack_status_d = rx_byte;
					state_d      = ST_TAIL;
				end else begin
					crc_d   = crc_next;
					count_d = count_inc;
					if (data_done) state_d = ST_CRC;
				end
			end
			ST_CRC: begin
				state_d = (rx_byte == crc_q) ? ST_TAIL : ST_HEAD;
			end
			ST_TAIL: begin
				state_d = ST_HEAD;
			end
		endcase
	end

	always_comb begin
		res_valid = 1'b0;
		res_item  = '0;
		res_item.frame_address = {addr_hi_q, addr_lo_q};
		res_item.frame_type    = type_q;
		res_item.frame_length  = len_q;
		unique case (state_q)
			ST_LEN: begin
				res_valid = !len_ok;
				res_item.event_res    = EV_LEN_ERR;
				res_item.frame_type   = '0;
				res_item.frame_length = rx_byte;
			end
			ST_DATA: begin
				res_valid = !is_ack_q;
				res_item.event_res  = EV_PAYLOAD;
				res_item.byte_value = rx_byte;
				res_item.byte_index = count_q;
			end
			ST_CRC: begin
				res_valid = (rx_byte != crc_q);
				res_item.event_res = EV_CRC_ERR;
			end
			ST_TAIL: begin
				res_valid = 1'b1;
				if (rx_byte != regs.tail_byte) begin
					res_item.event_res = EV_TAIL_ERR;
				end else if (is_ack_q) begin
					res_item.event_res  = EV_ACK_OK;
					res_item.byte_value = ack_status_q;
				end else begin
					res_item.event_res = EV_USER_OK;
				end
				if (is_ack_q) begin
					res_item.frame_address = '0;
					res_item.frame_type    = '0;
					res_item.frame_length  = '0;
				end
			end
			default: ;
		endcase
	end

	assign rx_ready = !ev_valid_q || ev_ready;
	assign accept   = rx_valid && rx_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_HEAD;
			is_ack_q     <= 1'b0;
			addr_phase_q <= 1'b0;
			addr_hi_q    <= '0;
			addr_lo_q    <= '0;
			len_q        <= '0;
			type_q       <= '0;
			count_q      <= '0;
			crc_q        <= CRC_INIT;
			ack_status_q <= '0;
			ev_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				state_q      <= state_d;
				is_ack_q     <= is_ack_d;
				addr_phase_q <= addr_phase_d;
				addr_hi_q    <= addr_hi_d;
				addr_lo_q    <= addr_lo_d;
				len_q        <= len_d;
				type_q       <= type_d;
				count_q      <= count_d;
				crc_q        <= crc_d;
				ack_status_q <= ack_status_d;
				ev_valid_q   <= res_valid;
			end else if (ev_ready) begin
				ev_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_valid) ev_item_q <= res_item;
	end

	assign ev_valid = ev_valid_q;
	assign ev_item  = ev_item_q;

endmodule

@@ hdl/serial_frame_receiver_crc8.sv @@
// Top level of the serial frame receiver with CRC-8 check.
//
//   Channel  Direction  Content
//   rx       in         one received byte per transaction
//   ev       out        one frame event per transaction
//   cfg      in         register index and write data
//
// One byte is taken per cycle while the output register can take it; the event it causes
// appears in the output register in the next cycle, with the new parse state and CRC.
// A new byte is taken whenever the output register is empty or is being emptied.
// Reset returns the parser to waiting for a head byte and loads the register defaults.
// Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
module serial_frame_receiver_crc8 (
	input logic          clk,
	input logic          arst_n,
	sfr_rx_if.sink       rx,
	sfr_ev_if.source     ev,
	sfr_cfg_if.sink      cfg
);
	import sfr_pkg::*;

	cfg_regs_t regs;

	assign cfg.ready = 1'b1;

	sfr_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg.valid),
		.wr_index (cfg.payload.reg_index),
		.wr_data  (cfg.payload.reg_data),
		.regs     (regs)
	);

	sfr_parser u_parser (
		.clk      (clk),
		.arst_n   (arst_n),
		.regs     (regs),
		.rx_valid (rx.valid),
		.rx_ready (rx.ready),
		.rx_byte  (rx.payload.rx_byte),
		.ev_valid (ev.valid),
		.ev_ready (ev.ready),
		.ev_item  (ev.payload)
	);

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!ev.valid |-> rx.ready)
		else $error("input stalled while the output register is empty");

	a_ack_no_user_info: assert property (@(posedge clk) disable iff (!arst_n)
		(ev.valid && ev.payload.event_res == EV_ACK_OK) |->
		(ev.payload.frame_address == '0 && ev.payload.frame_type == '0))
		else $error("acknowledge event carries user frame fields");

	a_index_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(ev.valid && ev.payload.event_res == EV_PAYLOAD) |->
		(({1'b0, ev.payload.byte_index} + 9'd2) < {1'b0, ev.payload.frame_length}))
		else $error("payload index beyond the frame length");

endmodule

@@ verif/serial_frame_receiver_crc8_test.sv @@
// Self-checking testbench for the serial frame receiver with CRC-8 check.
`timescale 1ns / 1ps
module serial_frame_receiver_crc8_test;
	import sfr_pkg::*;

	localparam int unsigned LONG_HOLD      = 300;
	localparam int unsigned WATCHDOG_LIMIT = 3000;
	localparam int unsigned PHASE_ITEMS    = 40;
	localparam int unsigned MAX_REPORTS    = 200;
	localparam logic [REG_IDX_W-1:0] REG_SPARE = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic      rx_valid = 1'b0;
	rx_item_t  rx_data = '0;
	logic      ev_ready = 1'b0;
	logic      cfg_valid = 1'b0;
	cfg_item_t cfg_data = '0;

	sfr_rx_if  rx_ch();
	sfr_ev_if  ev_ch();
	sfr_cfg_if cfg_ch();

	assign rx_ch.valid    = rx_valid;
	assign rx_ch.payload  = rx_data;
	assign ev_ch.ready    = ev_ready;
	assign cfg_ch.valid   = cfg_valid;
	assign cfg_ch.payload = cfg_data;

	serial_frame_receiver_crc8 u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx(rx_ch),
		.ev(ev_ch),
		.cfg(cfg_ch)
	);

	always #5 clk = ~clk;

	logic [BYTE_W-1:0] byte_stream[$];
	cfg_item_t         reg_writes[$];
	ev_item_t          expected_events[$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	int unsigned hold_trigger = 0;
	int unsigned hold_seen = 0;
	int unsigned hold_left = 0;
	int unsigned quiet_cycles = 0;
	int unsigned mismatches = 0;
	int unsigned stim_count = 0;

	cfg_regs_t         regs_now = '{HEAD_RST, TAIL_RST, ACK_RST, USER_RST, LIMIT_RST};
	parse_state_t      rx_state = ST_HEAD;
	logic              in_ack = 1'b0;
	logic              addr_second = 1'b0;
	logic [BYTE_W-1:0] addr_msb = '0;
	logic [BYTE_W-1:0] addr_lsb = '0;
	logic [BYTE_W-1:0] frame_len = '0;
	logic [BYTE_W-1:0] frame_kind = '0;
	logic [BYTE_W-1:0] data_seen = '0;
	logic [BYTE_W-1:0] crc_acc = CRC_INIT;
	logic [BYTE_W-1:0] ack_code = '0;

	function automatic logic [BYTE_W-1:0] crc8_step(input logic [BYTE_W-1:0] acc,
			input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] c;
		c = acc ^ b;
		for (int k = 0; k < 8; k++)
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		return c;
	endfunction

	function automatic ev_item_t frame_event(input ev_code_t code, input logic [BYTE_W-1:0] val,
			input logic [BYTE_W-1:0] idx, input bit with_frame);
		ev_item_t e;
		e.event_res     = code;
		e.byte_value    = val;
		e.byte_index    = idx;
		e.frame_address = with_frame ? {addr_msb, addr_lsb} : '0;
		e.frame_type    = with_frame ? frame_kind : '0;
		e.frame_length  = with_frame ? frame_len : '0;
		return e;
	endfunction

	function automatic void parse_byte(input logic [BYTE_W-1:0] b);
		logic [BYTE_W-1:0] idx;
		case (rx_state)
			ST_HEAD: begin
				if (b == regs_now.head_byte)
					rx_state = ST_TYPE;
			end
			ST_TYPE: begin
				if (b == regs_now.ack_type_byte) begin
					in_ack = 1'b1;
					rx_state = ST_DATA;
				end else if (b == regs_now.user_type_byte) begin
					in_ack = 1'b0;
					addr_second = 1'b0;
					rx_state = ST_ADDR;
				end else begin
					in_ack = 1'b0;
					rx_state = ST_HEAD;
				end
			end
			ST_ADDR: begin
				if (!addr_second) begin
					addr_msb = b;
					addr_second = 1'b1;
				end else begin
					addr_lsb = b;
					addr_second = 1'b0;
					rx_state = ST_LEN;
				end
			end
			ST_LEN: begin
				frame_len = b;
				if (b < regs_now.length_limit && b >= LEN_MIN) begin
					crc_acc = crc8_step(CRC_INIT, b);
					rx_state = ST_UTYPE;
				end else begin
					rx_state = ST_HEAD;
					frame_kind = '0;
					expected_events.push_back(frame_event(EV_LEN_ERR, '0, '0, 1'b1));
				end
			end
			ST_UTYPE: begin
				frame_kind = b;
				crc_acc = crc8_step(crc_acc, b);
				data_seen = '0;
				rx_state = ST_DATA;
			end
			ST_DATA: begin
				if (in_ack) begin
					ack_code = b;
					rx_state = ST_TAIL;
				end else begin
					idx = data_seen;
					crc_acc = crc8_step(crc_acc, b);
					data_seen = data_seen + 1'b1;
					if (int'(data_seen) + int'(LEN_OVERHEAD) >= int'(frame_len))
						rx_state = ST_CRC;
					expected_events.push_back(frame_event(EV_PAYLOAD, b, idx, 1'b1));
				end
			end
			ST_CRC: begin
				if (b == crc_acc) begin
					rx_state = ST_TAIL;
				end else begin
					rx_state = ST_HEAD;
					expected_events.push_back(frame_event(EV_CRC_ERR, '0, '0, 1'b1));
				end
			end
			default: begin
				rx_state = ST_HEAD;
				if (b != regs_now.tail_byte)
					expected_events.push_back(frame_event(EV_TAIL_ERR, '0, '0, !in_ack));
				else if (in_ack)
					expected_events.push_back(frame_event(EV_ACK_OK, ack_code, '0, 1'b0));
				else
					expected_events.push_back(frame_event(EV_USER_OK, '0, '0, 1'b1));
			end
		endcase
	endfunction

	function automatic void apply_reg(input cfg_item_t w);
		case (w.reg_index)
			REG_HEAD:  regs_now.head_byte = w.reg_data;
			REG_TAIL:  regs_now.tail_byte = w.reg_data;
			REG_ACK:   regs_now.ack_type_byte = w.reg_data;
			REG_USER:  regs_now.user_type_byte = w.reg_data;
			REG_LIMIT: regs_now.length_limit = w.reg_data;
			default: ;
		endcase
	endfunction

	task automatic log_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	task automatic check_event(input ev_item_t got);
		ev_item_t want;
		if (expected_events.size() == 0) begin
			log_mismatch($sformatf("unexpected event %0d", got.event_res));
		end else begin
			want = expected_events.pop_front();
			if (got.event_res !== want.event_res)
				log_mismatch($sformatf("event_res %0d, want %0d", got.event_res, want.event_res));
			if (got.byte_value !== want.byte_value)
				log_mismatch($sformatf("byte_value %h, want %h", got.byte_value, want.byte_value));
			if (got.byte_index !== want.byte_index)
				log_mismatch($sformatf("byte_index %0d, want %0d", got.byte_index, want.byte_index));
			if (got.frame_address !== want.frame_address)
				log_mismatch($sformatf("frame_address %h, want %h",
					got.frame_address, want.frame_address));
			if (got.frame_type !== want.frame_type)
				log_mismatch($sformatf("frame_type %h, want %h", got.frame_type, want.frame_type));
			if (got.frame_length !== want.frame_length)
				log_mismatch($sformatf("frame_length %0d, want %0d",
					got.frame_length, want.frame_length));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_valid <= 1'b0;
		end else begin
			if (rx_valid && rx_ch.ready)
				parse_byte(rx_data.rx_byte);
			if (!rx_valid || rx_ch.ready) begin
				if (byte_stream.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					rx_valid <= 1'b1;
					rx_data.rx_byte <= byte_stream.pop_front();
				end else begin
					rx_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ch.ready)
				apply_reg(cfg_data);
			if (!cfg_valid || cfg_ch.ready) begin
				if (reg_writes.size() > 0) begin
					cfg_valid <= 1'b1;
					cfg_data <= reg_writes.pop_front();
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ev_ready <= 1'b0;
			hold_left <= 0;
			hold_seen <= 0;
		end else begin
			if (ev_ch.valid && ev_ready)
				check_event(ev_ch.payload);
			if (hold_seen != hold_trigger) begin
				hold_seen <= hold_trigger;
				hold_left <= LONG_HOLD;
				ev_ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				ev_ready <= 1'b0;
			end else begin
				ev_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quiet_cycles <= 0;
		end else if ((rx_valid && rx_ch.ready) || (ev_ch.valid && ev_ready) ||
				(cfg_valid && cfg_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("[%0t] no transaction for %0d cycles", $time, quiet_cycles);
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_byte(input logic [BYTE_W-1:0] b);
		byte_stream.push_back(b);
		stim_count++;
	endtask

	task automatic push_user_frame(input logic [ADDR_W-1:0] addr, input logic [BYTE_W-1:0] len,
			input logic [BYTE_W-1:0] ftype, input logic [BYTE_W-1:0] crc_flip,
			input logic [BYTE_W-1:0] tail_flip);
		logic [BYTE_W-1:0] crc;
		logic [BYTE_W-1:0] b;
		push_byte(regs_now.head_byte);
		push_byte(regs_now.user_type_byte);
		push_byte(addr[15:8]);
		push_byte(addr[7:0]);
		push_byte(len);
		push_byte(ftype);
		crc = crc8_step(crc8_step(CRC_INIT, len), ftype);
		for (int i = 0; i + int'(LEN_OVERHEAD) < int'(len); i++) begin
			b = BYTE_W'($urandom_range(255));
			crc = crc8_step(crc, b);
			push_byte(b);
		end
		push_byte(crc ^ crc_flip);
		push_byte(regs_now.tail_byte ^ tail_flip);
	endtask

	task automatic push_ack_frame(input logic [BYTE_W-1:0] status,
			input logic [BYTE_W-1:0] tail_flip);
		push_byte(regs_now.head_byte);
		push_byte(regs_now.ack_type_byte);
		push_byte(status);
		push_byte(regs_now.tail_byte ^ tail_flip);
	endtask

	function automatic logic [BYTE_W-1:0] pick_len();
		int hi;
		int r;
		hi = int'(regs_now.length_limit) - 1;
		r = $urandom_range(19);
		if (r == 0)
			return BYTE_W'($urandom_range(6, hi));
		else if (r == 1)
			return BYTE_W'(hi);
		else
			return BYTE_W'($urandom_range(6, hi < 12 ? hi : 12));
	endfunction

	task automatic push_random_frame();
		int kind;
		logic [BYTE_W-1:0] b;
		logic [BYTE_W-1:0] flip;
		kind = $urandom_range(99);
		flip = BYTE_W'($urandom_range(1, 255));
		if (kind < 45) begin
			push_user_frame(ADDR_W'($urandom_range(16'hFFFF)), pick_len(),
				BYTE_W'($urandom_range(255)), '0, '0);
		end else if (kind < 60) begin
			push_ack_frame(BYTE_W'($urandom_range(255)), '0);
		end else if (kind < 68) begin
			push_user_frame(ADDR_W'($urandom_range(16'hFFFF)), pick_len(),
				BYTE_W'($urandom_range(255)), flip, '0);
		end else if (kind < 76) begin
			push_user_frame(ADDR_W'($urandom_range(16'hFFFF)), pick_len(),
				BYTE_W'($urandom_range(255)), '0, flip);
		end else if (kind < 82) begin
			push_ack_frame(BYTE_W'($urandom_range(255)), flip);
		end else if (kind < 88) begin
			push_byte(regs_now.head_byte);
			push_byte(regs_now.user_type_byte);
			push_byte(BYTE_W'($urandom_range(255)));
			push_byte(BYTE_W'($urandom_range(255)));
			if ($urandom_range(1))
				push_byte(BYTE_W'($urandom_range(5)));
			else
				push_byte(BYTE_W'($urandom_range(int'(regs_now.length_limit), 255)));
		end else if (kind < 92) begin
			do
				b = BYTE_W'($urandom_range(255));
			while (b == regs_now.ack_type_byte || b == regs_now.user_type_byte);
			push_byte(regs_now.head_byte);
			push_byte(b);
		end else if (kind < 97) begin
			repeat ($urandom_range(1, 3)) begin
				do
					b = BYTE_W'($urandom_range(255));
				while (b == regs_now.head_byte);
				push_byte(b);
			end
		end else begin
			push_byte(regs_now.head_byte);
			push_byte(regs_now.user_type_byte);
			repeat ($urandom_range(0, 3))
				push_byte(BYTE_W'($urandom_range(255)));
		end
	endtask

	task automatic wait_idle();
		while (byte_stream.size() > 0 || rx_valid || expected_events.size() > 0 ||
				reg_writes.size() > 0 || cfg_valid)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_regs(input logic [BYTE_W-1:0] head, input logic [BYTE_W-1:0] tail,
			input logic [BYTE_W-1:0] ack, input logic [BYTE_W-1:0] user,
			input logic [BYTE_W-1:0] limit);
		wait_idle();
		reg_writes.push_back('{REG_HEAD, head});
		reg_writes.push_back('{REG_TAIL, tail});
		reg_writes.push_back('{REG_ACK, ack});
		reg_writes.push_back('{REG_USER, user});
		reg_writes.push_back('{REG_LIMIT, limit});
		wait_idle();
	endtask

	initial begin
		logic [BYTE_W-1:0] same_type;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		push_ack_frame(8'hFF, '0);
		push_user_frame(16'hFF00, LEN_MIN, 8'hFF, '0, '0);
		push_byte(regs_now.head_byte);
		push_byte(8'h03);
		push_byte(regs_now.head_byte);
		push_byte(regs_now.user_type_byte);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(LEN_MIN - 1'b1);
		push_byte(8'h00);
		push_byte(8'hFF);

		for (int phase = 0; phase < 5; phase++) begin
			case (phase)
				1: set_regs(8'h00, 8'hFF, 8'hFF, 8'h00, 8'd7);
				2: set_regs(8'hFF, 8'h00, 8'h00, 8'hFF, 8'd255);
				3: begin
					same_type = BYTE_W'($urandom_range(255));
					set_regs(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
						same_type, same_type, BYTE_W'($urandom_range(7, 255)));
					reg_writes.push_back('{REG_SPARE, 8'h3C});
					wait_idle();
				end
				4: set_regs(BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
					BYTE_W'($urandom_range(255)), BYTE_W'($urandom_range(255)),
					BYTE_W'($urandom_range(7, 40)));
				default: ;
			endcase
			send_idle_pct  = (phase == 1) ? 55 : (phase == 3) ? 25 : 0;
			recv_stall_pct = (phase == 2) ? 55 : (phase == 3) ? 25 : 0;
			if (phase == 2)
				push_user_frame(ADDR_W'($urandom_range(16'hFFFF)), 8'd254,
					BYTE_W'($urandom_range(255)), '0, '0);
			stim_count = 0;
			while (stim_count < PHASE_ITEMS)
				push_random_frame();
			if (phase == 0)
				hold_trigger++;
		end

		wait_idle();
		repeat (8) @(negedge clk);
		if (mismatches == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
